>>> hdl/multilevel_priority_fifo_top_defines.svh
// Assertion macros for the multilevel priority FIFO.
// No dependencies; included by the modules that carry assertions.
`ifndef MULTILEVEL_PRIORITY_FIFO_TOP_DEFINES_SVH
`define MULTILEVEL_PRIORITY_FIFO_TOP_DEFINES_SVH
`ifndef SYNTH
`define MPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/mpf_pkg.sv
// Shared types and constants for the multilevel priority FIFO.
// No dependencies; imported by every module of the block.
package mpf_pkg;

	localparam int LEVELS_DEF  = 4;
	localparam int ENTRIES_DEF = 4;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_OVERFLOW = 2'd1;
	localparam logic [1:0] STS_EMPTY    = 2'd2;

	typedef struct packed {
		logic               func;
		logic [1:0]         level;
		logic signed [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [1:0]         out_level;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load_rd;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_remove;
		logic any_ready;
	} dp_sts_t;

endpackage

>>> hdl/mpf_ctrl.sv
// Controller state machine of the multilevel priority FIFO.
// Depends on mpf_pkg and the assertion macro header.
`include "multilevel_priority_fifo_top_defines.svh"

module mpf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output mpf_pkg::ctl_cmd_t cmd,
	input  mpf_pkg::dp_sts_t  sts
);
	import mpf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.is_remove && sts.any_ready) state_d = ST_READ;
				else state_d = ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_READ: begin
				cmd.load_rd = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	`MPF_ASSERT_IMPL(a_read_after_exec, clk, arst_n, state_q == ST_READ, $past(state_q) == ST_EXEC)
	`MPF_ASSERT_NEXT(a_accept_to_exec, clk, arst_n, start && !busy, state_q == ST_EXEC)

endmodule

>>> hdl/mpf_dp.sv
// Datapath of the multilevel priority FIFO: entry memory, per-level
// head and fill registers, level select and result register. Depends on mpf_pkg.
`include "multilevel_priority_fifo_top_defines.svh"

module mpf_dp #(
	parameter int LEVELS            = mpf_pkg::LEVELS_DEF,
	parameter int ENTRIES_PER_LEVEL = mpf_pkg::ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mpf_pkg::req_t     req,
	input  mpf_pkg::ctl_cmd_t cmd,
	output mpf_pkg::dp_sts_t  sts,
	output mpf_pkg::rsp_t     rsp,
	output logic             done
);
	import mpf_pkg::*;

	localparam int LW    = $clog2(LEVELS);
	localparam int SW    = $clog2(ENTRIES_PER_LEVEL);
	localparam int CW    = $clog2(ENTRIES_PER_LEVEL + 1);
	localparam int DEPTH = LEVELS * ENTRIES_PER_LEVEL;
	localparam int AW    = $clog2(DEPTH);

	req_t          req_q;
	logic [SW-1:0] head_q  [LEVELS];
	logic [CW-1:0] count_q [LEVELS];
	logic [31:0]   mem     [DEPTH];
	logic [31:0]   rd_data_q;
	logic [LW-1:0] rd_level_q;
	rsp_t          rsp_q;
	logic          done_q;

	logic          ins_lvl_ok;
	logic [LW-1:0] ins_idx;
	logic [CW-1:0] ins_cnt;
	logic          ins_full;
	logic [SW:0]   tail_sum;
	logic [SW-1:0] tail_slot;
	logic          ins_we;
	logic [AW-1:0] waddr;

	logic [LW-1:0] rm_idx;
	logic          rm_any;
	logic [SW-1:0] rm_head;
	logic [SW-1:0] rm_head_nxt;
	logic          rm_go;
	logic [AW-1:0] raddr;

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req;
	end

	assign ins_lvl_ok = (32'(req_q.level) < 32'(LEVELS));
	assign ins_idx    = LW'(req_q.level);
	assign ins_cnt    = ins_lvl_ok ? count_q[ins_idx] : CW'(ENTRIES_PER_LEVEL);
	assign ins_full   = !ins_lvl_ok || (ins_cnt == CW'(ENTRIES_PER_LEVEL));
	assign tail_sum   = (SW+1)'(head_q[ins_idx]) + (SW+1)'(ins_cnt);
	assign tail_slot  = (tail_sum >= (SW+1)'(ENTRIES_PER_LEVEL)) ?
		SW'(tail_sum - (SW+1)'(ENTRIES_PER_LEVEL)) : SW'(tail_sum);
	assign waddr      = AW'(AW'(ins_idx) * AW'(ENTRIES_PER_LEVEL) + AW'(tail_slot));
	assign ins_we     = cmd.exec && (req_q.func == FUNC_INSERT) && !ins_full;

	always_comb begin
		rm_idx = '0;
		rm_any = 1'b0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				rm_idx = LW'(i);
				rm_any = 1'b1;
			end
		end
	end

	assign rm_head     = head_q[rm_idx];
	assign rm_head_nxt = (rm_head == SW'(ENTRIES_PER_LEVEL - 1)) ? '0 : rm_head + SW'(1);
	assign raddr       = AW'(AW'(rm_idx) * AW'(ENTRIES_PER_LEVEL) + AW'(rm_head));
	assign rm_go       = cmd.exec && (req_q.func == FUNC_REMOVE) && rm_any;

	assign sts.is_remove = (req_q.func == FUNC_REMOVE);
	assign sts.any_ready = rm_any;

	always_ff @(posedge clk) begin
		if (ins_we) mem[waddr] <= req_q.item_value;
		if (rm_go) begin
			rd_data_q  <= mem[raddr];
			rd_level_q <= rm_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (ins_we) count_q[ins_idx] <= ins_cnt + CW'(1);
			if (rm_go) begin
				head_q[rm_idx]  <= rm_head_nxt;
				count_q[rm_idx] <= count_q[rm_idx] - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.exec && !rm_go) || cmd.load_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rd) begin
			rsp_q.out_value <= rd_data_q;
			rsp_q.out_level <= 2'(rd_level_q);
			rsp_q.status    <= STS_OK;
		end else if (cmd.exec && !rm_go) begin
			rsp_q.out_value <= '0;
			rsp_q.out_level <= '0;
			if (req_q.func == FUNC_REMOVE) rsp_q.status <= STS_EMPTY;
			else if (ins_full) rsp_q.status <= STS_OVERFLOW;
			else rsp_q.status <= STS_OK;
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

	`MPF_ASSERT_IMPL(a_load_after_exec, clk, arst_n, cmd.load_rd, $past(cmd.exec))
	`MPF_ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q)

endmodule

>>> hdl/multilevel_priority_fifo_top.sv
// Multilevel priority FIFO top level; depends on mpf_pkg, mpf_ctrl, mpf_dp.
// Insert and empty remove go through exec and raise done from a register; a remove of a word
// also passes the read state, where the registered memory read is loaded into the result.
// The controller is busy in exec and read, so a new word is accepted only once it is idle again.
// done is high for one cycle; the next word can be accepted in that cycle.
// Reset: arst_n clears the controller and every level to empty; entries are not cleared.
module multilevel_priority_fifo_top #(
	parameter int LEVELS            = mpf_pkg::LEVELS_DEF,
	parameter int ENTRIES_PER_LEVEL = mpf_pkg::ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mpf_pkg::req_t  req,
	output mpf_pkg::rsp_t  rsp,
	output logic          done
);
	import mpf_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	mpf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	mpf_dp #(
		.LEVELS            (LEVELS),
		.ENTRIES_PER_LEVEL (ENTRIES_PER_LEVEL)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

>>> tb/sv/multilevel_priority_fifo_top_tb.sv
// Self-checking testbench for multilevel_priority_fifo_top: directed and random inserts/removes
// against a per-level FIFO predictor, with random sender gaps and drain pauses.
// Depends on mpf_pkg and the RTL of the block.
module multilevel_priority_fifo_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mpf_pkg::*;

	localparam int LEVELS      = LEVELS_DEF;
	localparam int ENTRIES     = ENTRIES_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_WORDS  = 1100;

	typedef struct {
		req_t        word;
		int unsigned gap;
		bit          drain;
	} pending_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	multilevel_priority_fifo_top #(
		.LEVELS(LEVELS),
		.ENTRIES_PER_LEVEL(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.rsp(rsp),
		.done(done)
	);

	always #2 clk = ~clk;

	// predictor state
	logic signed [31:0] lvl_data [LEVELS][ENTRIES];
	int unsigned        lvl_head [LEVELS];
	int unsigned        lvl_count [LEVELS];

	pending_t word_q[$];
	rsp_t     expected_rsp[$];

	int unsigned n_words, n_inserts, n_full, n_removes, n_empty, n_pauses;
	int unsigned n_mismatch, stall_cycles, gap_left;
	bit          gap_loaded, next_start;
	int unsigned per_level_out [LEVELS];

	function automatic rsp_t queue_engine_step(req_t w);
		rsp_t r;
		int unsigned lv, slot;
		r = '0;
		if (w.func == FUNC_INSERT) begin
			lv = w.level;
			n_inserts++;
			if (lv >= LEVELS || lvl_count[lv] >= ENTRIES) begin
				r.status = STS_OVERFLOW;
				n_full++;
			end else begin
				slot = (lvl_head[lv] + lvl_count[lv]) % ENTRIES;
				lvl_data[lv][slot] = w.item_value;
				lvl_count[lv]++;
				r.status = STS_OK;
			end
		end else begin
			n_removes++;
			r.status = STS_EMPTY;
			for (int i = 0; i < LEVELS; i++) begin
				if (r.status == STS_EMPTY && lvl_count[i] != 0) begin
					r.out_value = lvl_data[i][lvl_head[i]];
					r.out_level = i[1:0];
					r.status = STS_OK;
					lvl_head[i] = (lvl_head[i] + 1) % ENTRIES;
					lvl_count[i]--;
					per_level_out[i]++;
				end
			end
			if (r.status == STS_EMPTY)
				n_empty++;
		end
		return r;
	endfunction

	function automatic void add_word(logic func, logic [1:0] level, logic [31:0] value,
			int unsigned gap, bit drain);
		pending_t p;
		p.word.func = func;
		p.word.level = level;
		p.word.item_value = value;
		p.gap = gap;
		p.drain = drain;
		word_q.push_back(p);
	endfunction

	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left = 0;
			gap_loaded = 1'b0;
		end else begin
			if (start && !busy) begin
				expected_rsp.push_back(queue_engine_step(req));
				n_words++;
			end
			if (!(start && busy)) begin
				next_start = 1'b0;
				if (word_q.size() > 0) begin
					if (!gap_loaded) begin
						gap_left = word_q[0].gap;
						gap_loaded = 1'b1;
					end
					if (gap_left > 0) begin
						gap_left--;
					end else if (word_q[0].drain && expected_rsp.size() > 0) begin
						next_start = 1'b0;
					end else begin
						if (word_q[0].drain)
							n_pauses++;
						req <= word_q[0].word;
						word_q.pop_front();
						gap_loaded = 1'b0;
						next_start = 1'b1;
					end
				end
				start <= next_start;
			end
		end
	end

	task automatic report_mismatch(string what, rsp_t want, rsp_t got);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("%0t mismatch (%s): expected value=%0d level=%0d status=%0d, got value=%0d level=%0d status=%0d",
				$realtime, what, want.out_value, want.out_level, want.status,
				got.out_value, got.out_level, got.status);
	endtask

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("no word expected", '0, rsp);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.out_value !== want.out_value)
					report_mismatch("out_value", want, rsp);
				else if (rsp.out_level !== want.out_level)
					report_mismatch("out_level", want, rsp);
				else if (rsp.status !== want.status)
					report_mismatch("status", want, rsp);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		int unsigned made, mode, len, ins_pct, hot_level;
		bit quiet;
		logic [1:0] lv;

		// directed
		add_word(FUNC_REMOVE, 2'd3, 32'hFFFF_FFFF, 0, 1'b0);
		add_word(FUNC_INSERT, 2'd0, 32'h8000_0000, 0, 1'b0);
		add_word(FUNC_INSERT, 2'd0, 32'h7FFF_FFFF, 0, 1'b0);
		add_word(FUNC_INSERT, 2'd0, 32'h0, 0, 1'b0);
		add_word(FUNC_INSERT, 2'd0, 32'hFFFF_FFFF, 0, 1'b0);
		add_word(FUNC_INSERT, 2'd0, 32'h1234_5678, 0, 1'b0);
		add_word(FUNC_INSERT, 2'd3, 32'h5A5A_A5A5, 0, 1'b0);
		add_word(FUNC_INSERT, 2'd2, 32'hA5A5_5A5A, 0, 1'b0);
		add_word(FUNC_INSERT, 2'd1, 32'h0000_0001, 0, 1'b0);
		for (int i = 0; i < 4; i++)
			add_word(FUNC_REMOVE, 2'(i), 32'h8000_0000 >> i, 0, 1'b0);
		add_word(FUNC_REMOVE, 2'd2, 32'h7FFF_FFFF, 0, 1'b0);
		add_word(FUNC_REMOVE, 2'd0, 32'h0, 0, 1'b0);
		add_word(FUNC_REMOVE, 2'd1, 32'h0, 0, 1'b0);
		add_word(FUNC_REMOVE, 2'd3, 32'h0, 0, 1'b0);
		add_word(FUNC_INSERT, 2'd3, 32'hDEAD_BEEF, 0, 1'b1);
		add_word(FUNC_REMOVE, 2'd0, 32'h0, 0, 1'b0);

		// random bursts
		made = 0;
		while (made < RAND_WORDS) begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(8, 40);
			quiet = ($urandom_range(0, 9) < 3);
			hot_level = $urandom_range(0, LEVELS - 1);
			case (mode)
				0: ins_pct = 80;
				1: ins_pct = 25;
				2: ins_pct = 50;
				default: ins_pct = 70;
			endcase
			for (int i = 0; i < len; i++) begin
				lv = (mode == 3 && $urandom_range(0, 3) != 0) ? 2'(hot_level) : 2'($urandom);
				add_word(($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE,
					lv, pick_value(), pick_gap(quiet),
					(i == 0) && ($urandom_range(0, 5) == 0));
				made++;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (!(word_q.size() == 0 && !start && expected_rsp.size() == 0)
				&& stall_cycles < STALL_LIMIT)
			@(negedge clk);
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", stall_cycles);
			$display("FAILURE");
		end else begin
			repeat (10) @(negedge clk);
			$display("Ran %0d words: %0d inserts (%0d refused on a full level), %0d removes (%0d on empty).",
				n_words, n_inserts, n_full, n_removes, n_empty);
			$display("Removed per level: %0d/%0d/%0d/%0d, %0d drain pauses, %0d mismatches.",
				per_level_out[0], per_level_out[1], per_level_out[2], per_level_out[3],
				n_pauses, n_mismatch);
			if (n_mismatch == 0 && expected_rsp.size() == 0)
				$display("SUCCESS");
			else
				$display("FAILURE");
		end
		$finish;
	end

endmodule
